// ===== rtl/core/nsbr_pkg.sv =====
// Package for the nibble strobe byte receiver.
// Holds the word types, status codes and register constants used by the other receiver files.
// Depends on nothing.
package nsbr_pkg;

   localparam int unsigned CNT_W = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] SAMPLE_BUDGET_RESET = 16'd50000;
   localparam logic [CNT_W-1:0] MAX_BYTES_RESET = 16'd256;

   localparam logic REG_SAMPLE_BUDGET = 1'b0;
   localparam logic REG_MAX_BYTES = 1'b1;

   localparam logic [1:0] ST_LAST = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_BAD_START = 2'd3;

   typedef struct packed {
      logic       start_req;
      logic       clock_line;
      logic       last_line;
      logic [3:0] data_nibble;
   } sample_type;

   typedef struct packed {
      logic             byte_valid;
      logic [7:0]       byte_value;
      logic             frame_end;
      logic [1:0]       end_status;
      logic [CNT_W-1:0] byte_total;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0] sample_budget;
      logic [CNT_W-1:0] max_bytes;
   } cfg_type;

   typedef struct packed {
      logic       load;
      result_type res;
   } res_ctl_type;

endpackage

// ===== rtl/core/nsbr_channels.sv =====
// Channel interfaces of the nibble strobe byte receiver: pin samples in, results out.
// Depends on nsbr_pkg for the counter width.
interface nsbr_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic       clock_line;
   logic       last_line;
   logic [3:0] data_nibble;

   modport source (output valid, start_req, clock_line, last_line, data_nibble, input ready);
   modport sink (input valid, start_req, clock_line, last_line, data_nibble, output ready);
endinterface

interface nsbr_rsp_if
   import nsbr_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic             byte_valid;
   logic [7:0]       byte_value;
   logic             frame_end;
   logic [1:0]       end_status;
   logic [CNT_W-1:0] byte_total;

   modport source (output valid, byte_valid, byte_value, frame_end, end_status, byte_total,
                   input ready);
   modport sink (input valid, byte_valid, byte_value, frame_end, end_status, byte_total,
                 output ready);
endinterface

// ===== rtl/core/nsbr_csr.sv =====
// Configuration registers of the nibble strobe byte receiver on an APB-style port.
// Depends on nsbr_pkg.
module nsbr_csr
   import nsbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    reg_sel;
   logic    wr_en;

   assign reg_sel = csr_paddr[2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SAMPLE_BUDGET: cfg_in.sample_budget = csr_pwdata[CNT_W-1:0];
            REG_MAX_BYTES:     cfg_in.max_bytes = csr_pwdata[CNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SAMPLE_BUDGET: csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.sample_budget};
         REG_MAX_BYTES:     csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.max_bytes};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_budget <= SAMPLE_BUDGET_RESET;
         cfg_ff.max_bytes <= MAX_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/nsbr_step.sv =====
// Sample register and frame decoder of the nibble strobe byte receiver.
// Depends on nsbr_pkg and the request channel interface.
module nsbr_step
   import nsbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   nsbr_req_if.sink     req_ch,
   input  cfg_type      cfg,
   input  logic         out_free,
   output res_ctl_type  res_ctl
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_LOW,
      PH_WAIT_HIGH
   } phase_type;

   sample_type       sample_ff;
   logic             s_valid_ff;
   logic             s_valid_in;
   phase_type        phase_ff;
   phase_type        phase_in;
   logic [CNT_W-1:0] budget_ff;
   logic [CNT_W-1:0] budget_in;
   logic [CNT_W-1:0] bytes_ff;
   logic [CNT_W-1:0] bytes_in;
   logic [3:0]       lown_ff;
   logic [3:0]       lown_in;
   logic [CNT_W-1:0] budget_dec;
   logic [CNT_W-1:0] bytes_inc;
   logic             res_valid;
   result_type       res;
   logic             s_fire;
   logic             accept;

   assign budget_dec = budget_ff - 1'b1;
   assign bytes_inc = bytes_ff + 1'b1;

   always_comb begin
      phase_in = phase_ff;
      budget_in = budget_ff;
      bytes_in = bytes_ff;
      lown_in = lown_ff;
      res_valid = 1'b0;
      res = '0;
      if (sample_ff.start_req) begin
         bytes_in = '0;
         lown_in = '0;
         if (!(sample_ff.clock_line && sample_ff.last_line)) begin
            phase_in = PH_IDLE;
            budget_in = '0;
            res_valid = 1'b1;
            res.frame_end = 1'b1;
            res.end_status = ST_BAD_START;
         end else begin
            budget_in = cfg.sample_budget;
            if (cfg.max_bytes == '0) begin
               phase_in = PH_IDLE;
               res_valid = 1'b1;
               res.frame_end = 1'b1;
               res.end_status = ST_FULL;
            end else begin
               phase_in = PH_WAIT_LOW;
            end
         end
      end else begin
         unique case (phase_ff) inside
            PH_WAIT_LOW, PH_WAIT_HIGH: begin
               budget_in = budget_dec;
               if (budget_dec == '0) begin
                  phase_in = PH_IDLE;
                  res_valid = 1'b1;
                  res.frame_end = 1'b1;
                  res.end_status = ST_TIMEOUT;
                  res.byte_total = bytes_ff;
               end else if (phase_ff == PH_WAIT_LOW) begin
                  if (!sample_ff.clock_line) begin
                     lown_in = sample_ff.data_nibble;
                     phase_in = PH_WAIT_HIGH;
                  end
               end else if (sample_ff.clock_line) begin
                  bytes_in = bytes_inc;
                  res_valid = 1'b1;
                  res.byte_valid = 1'b1;
                  res.byte_value = {sample_ff.data_nibble, lown_ff};
                  res.byte_total = bytes_inc;
                  if (sample_ff.last_line) begin
                     phase_in = PH_IDLE;
                     res.frame_end = 1'b1;
                     res.end_status = ST_LAST;
                  end else if (bytes_inc >= cfg.max_bytes) begin
                     phase_in = PH_IDLE;
                     res.frame_end = 1'b1;
                     res.end_status = ST_FULL;
                  end else begin
                     phase_in = PH_WAIT_LOW;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   assign s_fire = s_valid_ff && (!res_valid || out_free);
   assign req_ch.ready = !s_valid_ff || s_fire;
   assign accept = req_ch.valid && req_ch.ready;
   assign s_valid_in = accept || (s_valid_ff && !s_fire);

   assign res_ctl.load = s_fire && res_valid;
   assign res_ctl.res = res;

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff.start_req <= req_ch.start_req;
         sample_ff.clock_line <= req_ch.clock_line;
         sample_ff.last_line <= req_ch.last_line;
         sample_ff.data_nibble <= req_ch.data_nibble;
      end
      if (reset) begin
         s_valid_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         budget_ff <= '0;
         bytes_ff <= '0;
         lown_ff <= '0;
      end else begin
         s_valid_ff <= s_valid_in;
         if (s_fire) begin
            phase_ff <= phase_in;
            budget_ff <= budget_in;
            bytes_ff <= bytes_in;
            lown_ff <= lown_in;
         end
      end
   end

endmodule

// ===== rtl/core/nsbr_out.sv =====
// Result register of the nibble strobe byte receiver driving the result channel.
// Depends on nsbr_pkg and the result channel interface.
module nsbr_out
   import nsbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  res_ctl_type  res_ctl,
   output logic         out_free,
   nsbr_rsp_if.source   rsp_ch
);

   result_type res_ff;
   logic       valid_ff;
   logic       valid_in;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign valid_in = res_ctl.load || (valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.byte_valid = res_ff.byte_valid;
   assign rsp_ch.byte_value = res_ff.byte_value;
   assign rsp_ch.frame_end = res_ff.frame_end;
   assign rsp_ch.end_status = res_ff.end_status;
   assign rsp_ch.byte_total = res_ff.byte_total;

   always_ff @(posedge clock) begin
      if (res_ctl.load) begin
         res_ff <= res_ctl.res;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/core/nibble_strobe_byte_receiver.sv =====
// Top level of the nibble strobe byte receiver.
// Depends on nsbr_pkg, the channel interfaces, nsbr_csr, nsbr_step and nsbr_out.
//
//   Channel   Direction  Handshake               Word
//   req_ch    in         valid/ready             one pin sample
//   rsp_ch    out        valid/ready             one byte or frame end
//   csr_*     in         APB r/w, pready = 1     sample_budget, max_bytes
//
// One word is taken every cycle unless a stalled result holds it; a result passes the sample then result register.
// The sample register and the result register each hold one word, so a
// stalled result only stops input once both are occupied.
// Reset is synchronous and returns the receiver to idle with reset register values.
module nibble_strobe_byte_receiver
   import nsbr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   nsbr_req_if.sink              req_ch,
   nsbr_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg;
   res_ctl_type res_ctl;
   logic        out_free;

   nsbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   nsbr_step u_step (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cfg      (cfg),
      .out_free (out_free),
      .res_ctl  (res_ctl)
   );

   nsbr_out u_out (
      .clock    (clock),
      .reset    (reset),
      .res_ctl  (res_ctl),
      .out_free (out_free),
      .rsp_ch   (rsp_ch)
   );

endmodule
